/* sv/hrc_pkg.sv */
package hrc_pkg;

  localparam int ChanW = 8;

  localparam logic [ChanW-1:0] HueSector = 8'd43;
  localparam logic [ChanW-1:0] RemScale  = 8'd6;
  localparam logic [ChanW-1:0] Full      = 8'd255;
  localparam logic [ChanW-1:0] HueOffG   = 8'd85;
  localparam logic [ChanW-1:0] HueOffB   = 8'd171;

  typedef enum logic {
    REQ_HSV2RGB = 1'b0,
    REQ_RGB2HSV = 1'b1
  } req_t;

  typedef struct packed {
    logic [2*ChanW-1:0] rem;
    logic [ChanW-1:0]   quo;
  } div_st_t;

endpackage

/* sv/hrc_if.sv */
interface hrc_in_if import hrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [ChanW-1:0] chan_a;
  logic [ChanW-1:0] chan_b;
  logic [ChanW-1:0] chan_c;

  modport source (output valid, req_type, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, req_type, chan_a, chan_b, chan_c, output ready);
endinterface

interface hrc_out_if import hrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_a;
  logic [ChanW-1:0] out_b;
  logic [ChanW-1:0] out_c;

  modport source (output valid, out_a, out_b, out_c, input ready);
  modport sink   (input valid, out_a, out_b, out_c, output ready);
endinterface

/* sv/hrc_div_step.sv */
module hrc_div_step import hrc_pkg::*; (
  input  div_st_t          d_i,
  input  logic [ChanW-1:0] den,
  input  logic [2:0]       hi_bit,
  output div_st_t          d_o
);

  logic [2:0]         lo_bit;
  logic [2*ChanW-1:0] sh_hi;
  logic [2*ChanW-1:0] sh_lo;
  div_st_t            t;

  always_comb begin
    lo_bit = hi_bit - 3'd1;
    sh_hi  = {{ChanW{1'b0}}, den} << hi_bit;
    sh_lo  = {{ChanW{1'b0}}, den} << lo_bit;
    t      = d_i;
    if (t.rem >= sh_hi) begin
      t.rem         = t.rem - sh_hi;
      t.quo[hi_bit] = 1'b1;
    end
    if (t.rem >= sh_lo) begin
      t.rem         = t.rem - sh_lo;
      t.quo[lo_bit] = 1'b1;
    end
    d_o = t;
  end

endmodule

/* sv/hsv_rgb_color_converter.sv */
// HSV <-> RGB color converter, 8 bits per channel.
// in_chan carries one beat per pixel: req_type picks the direction
// (0: hue/sat/value to red/green/blue, 1: red/green/blue to hue/sat/value)
// and chan_a..chan_c carry the three source channels.
// out_chan carries one result beat per input beat, in order, on out_a..out_c.
// Both channels use valid/ready; a beat moves when both are high.
// The accepting edge loads the first of five pipeline stages, and the output
// register follows the last. The two divisions of the RGB path resolve two
// quotient bits per stage over four stages, which sets the depth; the HSV
// path multiplies in the same stages.
// Throughput: one beat per cycle, sustained while out_chan.ready stays high.
// Reset clears all stage valid bits; the pipe comes up empty and ready.
// When the receiver stalls, the result holds on out_chan, bubbles in the pipe
// close up, and in_chan.ready drops only once every stage holds a beat.
module hsv_rgb_color_converter import hrc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  hrc_in_if.sink    in_chan,
  hrc_out_if.source out_chan
);

  typedef enum logic [1:0] {
    MAX_R,
    MAX_G,
    MAX_B
  } maxsel_t;

  typedef struct packed {
    req_t             req;
    logic [2:0]       sector;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
    logic [ChanW-1:0] rem6;
    logic [ChanW-1:0] p;
    logic [ChanW-1:0] sr;
    logic [ChanW-1:0] st;
    logic [ChanW-1:0] q;
    logic [ChanW-1:0] t;
    logic [ChanW-1:0] rd;
    logic [ChanW-1:0] gr;
    logic [ChanW-1:0] bl;
    logic             active;
    logic             neg;
    logic [ChanW-1:0] den;
    logic [ChanW-1:0] hoff;
    logic [ChanW-1:0] mx;
    div_st_t          sat_dv;
    div_st_t          hue_dv;
  } pipe_t;

  pipe_t            st_r  [0:4];
  pipe_t            nx    [0:4];
  div_st_t          sdiv  [1:4];
  div_st_t          hdiv  [1:4];
  logic [5:0]       vld_r;
  logic [5:0]       en;
  logic [ChanW-1:0] oa_r, ob_r, oc_r;
  logic [ChanW-1:0] oa_nxt, ob_nxt, oc_nxt;

  logic [ChanW-1:0]   r, g, b, mn, mag, base, hq;
  logic [5:0]         hrem;
  logic [ChanW:0]     diff;
  maxsel_t            sel;
  logic [2*ChanW-1:0] mp, msr, mst, mq, mt;

  always_comb begin
    en[5] = !vld_r[5] || out_chan.ready;
    en[4] = !vld_r[4] || en[5];
    en[3] = !vld_r[3] || en[4];
    en[2] = !vld_r[2] || en[3];
    en[1] = !vld_r[1] || en[2];
    en[0] = !vld_r[0] || en[1];
  end

  assign in_chan.ready  = en[0];
  assign out_chan.valid = vld_r[5];
  assign out_chan.out_a = oa_r;
  assign out_chan.out_b = ob_r;
  assign out_chan.out_c = oc_r;

  for (genvar k = 1; k <= 4; k++) begin : g_div
    hrc_div_step u_sat (
      .d_i    (st_r[k-1].sat_dv),
      .den    (st_r[k-1].mx),
      .hi_bit (3'(9 - 2 * k)),
      .d_o    (sdiv[k])
    );
    hrc_div_step u_hue (
      .d_i    (st_r[k-1].hue_dv),
      .den    (st_r[k-1].den),
      .hi_bit (3'(9 - 2 * k)),
      .d_o    (hdiv[k])
    );
  end

  always_comb begin
    r = in_chan.chan_a;
    g = in_chan.chan_b;
    b = in_chan.chan_c;

    nx[0]     = '0;
    nx[0].req = req_t'(in_chan.req_type);

    nx[0].sector = 3'd0;
    base         = '0;
    for (int k = 1; k < 6; k++) begin
      if (r >= 8'(k * HueSector)) begin
        nx[0].sector = 3'(k);
        base         = 8'(k * HueSector);
      end
    end
    hrem        = 6'(r - base);
    nx[0].rem6  = 8'({2'b00, hrem} * RemScale);
    nx[0].sat   = g;
    nx[0].val   = b;

    if (r >= g && r >= b) begin
      sel = MAX_R;
    end else if (g >= b) begin
      sel = MAX_G;
    end else begin
      sel = MAX_B;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    case (sel)
      MAX_R: begin
        nx[0].mx   = r;
        diff       = {1'b0, g} - {1'b0, b};
        nx[0].hoff = '0;
      end
      MAX_G: begin
        nx[0].mx   = g;
        diff       = {1'b0, b} - {1'b0, r};
        nx[0].hoff = HueOffG;
      end
      default: begin
        nx[0].mx   = b;
        diff       = {1'b0, r} - {1'b0, g};
        nx[0].hoff = HueOffB;
      end
    endcase
    nx[0].neg        = diff[ChanW];
    mag              = diff[ChanW] ? 8'((ChanW+1)'(0) - diff) : diff[ChanW-1:0];
    nx[0].den        = nx[0].mx - mn;
    nx[0].active     = nx[0].den != '0;
    nx[0].sat_dv.rem = {nx[0].den, {ChanW{1'b0}}} - {{ChanW{1'b0}}, nx[0].den};
    nx[0].sat_dv.quo = '0;
    nx[0].hue_dv.rem = {{ChanW{1'b0}}, mag} * {{ChanW{1'b0}}, HueSector};
    nx[0].hue_dv.quo = '0;

    mp  = {{ChanW{1'b0}}, st_r[0].val} * {{ChanW{1'b0}}, Full - st_r[0].sat};
    msr = {{ChanW{1'b0}}, st_r[0].sat} * {{ChanW{1'b0}}, st_r[0].rem6};
    mst = {{ChanW{1'b0}}, st_r[0].sat} * {{ChanW{1'b0}}, Full - st_r[0].rem6};
    nx[1]        = st_r[0];
    nx[1].p      = mp[2*ChanW-1:ChanW];
    nx[1].sr     = msr[2*ChanW-1:ChanW];
    nx[1].st     = mst[2*ChanW-1:ChanW];
    nx[1].sat_dv = sdiv[1];
    nx[1].hue_dv = hdiv[1];

    mq = {{ChanW{1'b0}}, st_r[1].val} * {{ChanW{1'b0}}, Full - st_r[1].sr};
    mt = {{ChanW{1'b0}}, st_r[1].val} * {{ChanW{1'b0}}, Full - st_r[1].st};
    nx[2]        = st_r[1];
    nx[2].q      = mq[2*ChanW-1:ChanW];
    nx[2].t      = mt[2*ChanW-1:ChanW];
    nx[2].sat_dv = sdiv[2];
    nx[2].hue_dv = hdiv[2];

    nx[3] = st_r[2];
    case (st_r[2].sector)
      3'd0: begin
        nx[3].rd = st_r[2].val; nx[3].gr = st_r[2].t;   nx[3].bl = st_r[2].p;
      end
      3'd1: begin
        nx[3].rd = st_r[2].q;   nx[3].gr = st_r[2].val; nx[3].bl = st_r[2].p;
      end
      3'd2: begin
        nx[3].rd = st_r[2].p;   nx[3].gr = st_r[2].val; nx[3].bl = st_r[2].t;
      end
      3'd3: begin
        nx[3].rd = st_r[2].p;   nx[3].gr = st_r[2].q;   nx[3].bl = st_r[2].val;
      end
      3'd4: begin
        nx[3].rd = st_r[2].t;   nx[3].gr = st_r[2].p;   nx[3].bl = st_r[2].val;
      end
      default: begin
        nx[3].rd = st_r[2].val; nx[3].gr = st_r[2].p;   nx[3].bl = st_r[2].q;
      end
    endcase
    if (st_r[2].sat == '0) begin
      nx[3].rd = st_r[2].val;
      nx[3].gr = st_r[2].val;
      nx[3].bl = st_r[2].val;
    end
    nx[3].sat_dv = sdiv[3];
    nx[3].hue_dv = hdiv[3];

    nx[4]        = st_r[3];
    nx[4].sat_dv = sdiv[4];
    nx[4].hue_dv = hdiv[4];

    hq = st_r[4].neg ? (8'd0 - st_r[4].hue_dv.quo) : st_r[4].hue_dv.quo;
    if (st_r[4].req == REQ_HSV2RGB) begin
      oa_nxt = st_r[4].rd;
      ob_nxt = st_r[4].gr;
      oc_nxt = st_r[4].bl;
    end else begin
      oa_nxt = st_r[4].active ? (st_r[4].hoff + hq) : '0;
      ob_nxt = st_r[4].active ? st_r[4].sat_dv.quo : '0;
      oc_nxt = st_r[4].mx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_chan.valid;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
      if (en[3]) vld_r[3] <= vld_r[2];
      if (en[4]) vld_r[4] <= vld_r[3];
      if (en[5]) vld_r[5] <= vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) st_r[0] <= nx[0];
    if (en[1]) st_r[1] <= nx[1];
    if (en[2]) st_r[2] <= nx[2];
    if (en[3]) st_r[3] <= nx[3];
    if (en[4]) st_r[4] <= nx[4];
    if (en[5]) begin
      oa_r <= oa_nxt;
      ob_r <= ob_nxt;
      oc_r <= oc_nxt;
    end
  end

endmodule
